@@ sv/dmm_pkg.sv @@
// shared types, constants and sizes for the dense matrix multiply block
`default_nettype none
package dmm_pkg;

	// storage limits
	localparam int MAX_ROWS  = 64;
	localparam int MAX_INNER = 64;
	localparam int MAX_COLS  = 64;

	// field widths
	localparam int ROW_W  = 6;
	localparam int K_W    = $clog2(MAX_INNER);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int DIM_W  = 7;
	localparam int ELEM_W = 16;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int SUM_W  = 38;
	localparam int XADDR_W = ROW_W + K_W;

	// item kinds
	localparam logic [1:0] KIND_LOAD_X  = 2'd0;
	localparam logic [1:0] KIND_LOAD_Y  = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_ROWS_N  = 2'd0;
	localparam logic [1:0] CFG_INNER_D = 2'd1;
	localparam logic [1:0] CFG_COLS_M  = 2'd2;
	localparam logic [1:0] CFG_Y_TRANS = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic                     x_we;
		logic                     y_we;
		logic [ROW_W-1:0]         wr_row;
		logic [K_W-1:0]           wr_k;
		logic [COL_W-1:0]         wr_lane;
		logic signed [ELEM_W-1:0] wdata;
		logic                     rd_en;
		logic [ROW_W-1:0]         rd_row;
		logic [K_W-1:0]           rd_k;
		logic                     acc_clr;
		logic                     out_ld;
		logic [COL_W-1:0]         out_col;
		logic                     out_last;
		logic                     out_bad;
	} dmm_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dmm_stat_t;

endpackage
`default_nettype wire

@@ sv/dmm_lane.sv @@
// one result column: its slice of Y, a multiplier and an accumulator
`default_nettype none
module dmm_lane import dmm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [K_W-1:0]           wr_k,
	input  wire logic signed [ELEM_W-1:0] wdata,
	input  wire logic                     rd_en,
	input  wire logic [K_W-1:0]           rd_k,
	input  wire logic signed [ELEM_W-1:0] x_s1,
	input  wire logic                     v_s1,
	input  wire logic                     v_s2,
	input  wire logic                     acc_clr,
	output logic signed [SUM_W-1:0]       acc
);

	logic signed [ELEM_W-1:0] y_mem [MAX_INNER];
	logic signed [ELEM_W-1:0] y_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;

	// column memory, one element of Y(k, lane) per entry
	always_ff @(posedge clk) begin
		if (we)
			y_mem[wr_k] <= wdata;
		if (rd_en)
			y_s1 <= y_mem[rd_k];
	end

	// multiply stage
	always_ff @(posedge clk) begin
		if (v_s1)
			prod_s2 <= x_s1 * y_s1;
	end

	// accumulate, 64 terms of at most 2^30 never leave 38 bits
	always_ff @(posedge clk) begin
		if (acc_clr)
			acc_q <= '0;
		else if (v_s2)
			acc_q <= acc_q + SUM_W'(prod_s2);
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

@@ sv/dmm_datapath.sv @@
// X memory, column lanes and the result register
`default_nettype none
module dmm_datapath import dmm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire dmm_cmd_t           cmd,
	output dmm_stat_t               stat,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [COL_W-1:0]        out_col,
	output logic signed [SUM_W-1:0] dot_sum,
	output logic                    last_of_row,
	output logic                    bad_row
);

	logic signed [ELEM_W-1:0] x_mem [MAX_ROWS * MAX_INNER];
	logic signed [ELEM_W-1:0] x_s1;
	logic                     v_s1;
	logic                     v_s2;
	logic signed [SUM_W-1:0]  acc [MAX_COLS];
	logic                     out_valid_q;
	logic [COL_W-1:0]         out_col_q;
	logic signed [SUM_W-1:0]  dot_sum_q;
	logic                     last_q;
	logic                     bad_q;

	// X memory, row-major
	always_ff @(posedge clk) begin
		if (cmd.x_we)
			x_mem[{cmd.wr_row, cmd.wr_k}] <= cmd.wdata;
		if (cmd.rd_en)
			x_s1 <= x_mem[{cmd.rd_row, cmd.rd_k}];
	end

	// valid flags of the read and multiply stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	// one lane per result column
	for (genvar j = 0; j < MAX_COLS; j++) begin : g_lane
		dmm_lane u_lane (
			.clk     (clk),
			.we      (cmd.y_we && (cmd.wr_lane == COL_W'(j))),
			.wr_k    (cmd.wr_k),
			.wdata   (cmd.wdata),
			.rd_en   (cmd.rd_en),
			.rd_k    (cmd.rd_k),
			.x_s1    (x_s1),
			.v_s1    (v_s1),
			.v_s2    (v_s2),
			.acc_clr (cmd.acc_clr),
			.acc     (acc[j])
		);
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_ld)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_col_q <= cmd.out_col;
			dot_sum_q <= cmd.out_bad ? '0 : acc[cmd.out_col];
			last_q    <= cmd.out_last;
			bad_q     <= cmd.out_bad;
		end
	end

	assign stat.pipe_busy = v_s1 | v_s2;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_col     = out_col_q;
	assign dot_sum     = dot_sum_q;
	assign last_of_row = last_q;
	assign bad_row     = bad_q;

endmodule
`default_nettype wire

@@ sv/dmm_ctrl.sv @@
// controller: configuration registers, load decode and compute sequencing
`default_nettype none
module dmm_ctrl import dmm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [DIM_W-1:0]         cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               kind,
	input  wire logic [ROW_W-1:0]         row_index,
	input  wire logic [COL_W-1:0]         col_index,
	input  wire logic signed [ELEM_W-1:0] element_value,
	input  wire dmm_stat_t                stat,
	output dmm_cmd_t                      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_BAD   = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [DIM_W-1:0] rows_n_q, inner_d_q, cols_m_q;
	logic             y_trans_q;
	logic [DIM_W-1:0] en, ed, em;
	logic [ROW_W-1:0] row_q, row_d;
	logic [K_W-1:0]   k_q, k_d;
	logic [COL_W-1:0] col_q, col_d;
	logic             in_acc;
	logic [DIM_W-1:0] row_w, col_w;
	logic             k_last, col_last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_n_q  <= DIM_W'(1);
			inner_d_q <= DIM_W'(1);
			cols_m_q  <= DIM_W'(1);
			y_trans_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROWS_N:  rows_n_q  <= cfg_data;
				CFG_INNER_D: inner_d_q <= cfg_data;
				CFG_COLS_M:  cols_m_q  <= cfg_data;
				CFG_Y_TRANS: y_trans_q <= cfg_data[0];
			endcase
		end
	end

	// effective sizes, limited to the storage
	assign en = (rows_n_q  > DIM_W'(MAX_ROWS))  ? DIM_W'(MAX_ROWS)  : rows_n_q;
	assign ed = (inner_d_q > DIM_W'(MAX_INNER)) ? DIM_W'(MAX_INNER) : inner_d_q;
	assign em = (cols_m_q  > DIM_W'(MAX_COLS))  ? DIM_W'(MAX_COLS)  : cols_m_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign row_w    = DIM_W'(row_index);
	assign col_w    = DIM_W'(col_index);
	assign k_last   = (DIM_W'(k_q) + DIM_W'(1)) == ed;
	assign col_last = (DIM_W'(col_q) + DIM_W'(1)) == em;

	// next state and commands
	always_comb begin
		state_d      = state_q;
		row_d        = row_q;
		k_d          = k_q;
		col_d        = col_q;
		cmd          = '0;
		cmd.wdata    = element_value;
		cmd.wr_row   = row_index;
		cmd.rd_row   = row_q;
		cmd.rd_k     = k_q;
		cmd.out_col  = col_q;
		cmd.out_last = col_last;
		// Y element placement depends on the transpose setting at load time
		if (y_trans_q) begin
			cmd.wr_lane = row_index;
			cmd.wr_k    = K_W'(col_index);
		end else begin
			cmd.wr_lane = col_index;
			cmd.wr_k    = K_W'(row_index);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					priority if (kind == KIND_LOAD_X) begin
						// X is always row by inner index
						cmd.wr_k = K_W'(col_index);
						cmd.x_we = (row_w < en) && (col_w < ed);
					end else if (kind == KIND_LOAD_Y) begin
						if (y_trans_q)
							cmd.y_we = (row_w < em) && (col_w < ed);
						else
							cmd.y_we = (row_w < ed) && (col_w < em);
					end else if (kind == KIND_COMPUTE) begin
						row_d = row_index;
						k_d   = '0;
						col_d = '0;
						priority if (row_w >= en) begin
							state_d = ST_BAD;
						end else if (em != '0) begin
							cmd.acc_clr = 1'b1;
							state_d     = (ed == '0) ? ST_DRAIN : ST_RUN;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_RUN: begin
				// one inner term per cycle into every lane
				cmd.rd_en = 1'b1;
				k_d       = k_q + K_W'(1);
				if (k_last)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy)
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					col_d      = col_q + COL_W'(1);
					if (col_last)
						state_d = ST_IDLE;
				end
			end
			ST_BAD: begin
				cmd.out_col  = '0;
				cmd.out_last = 1'b1;
				cmd.out_bad  = 1'b1;
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			k_q     <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			k_q     <= k_d;
			col_q   <= col_d;
		end
	end

endmodule
`default_nettype wire

@@ sv/dense_matrix_multiply.sv @@
// Dense matrix multiply, out = X * Y over signed Q8.8 elements with exact Q.16
// results. Load transactions write one element of X or Y; out-of-range
// indices are dropped. A compute transaction for row i runs inner_d inner
// terms through 64 column lanes (one multiplier and accumulator per column,
// one inner term per cycle, fed by the X memory read port and each lane's Y
// memory), drains the read, multiply and accumulate stages, then hands out
// cols_m results one per cycle as the consumer takes them. A row at or past
// rows_n gives a single flagged result. Input is taken only while no compute
// is in progress; the result register lets a new transaction in while the
// last result waits.
`default_nettype none
module dense_matrix_multiply import dmm_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [DIM_W-1:0]         cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               kind,
	input  wire logic [ROW_W-1:0]         row_index,
	input  wire logic [COL_W-1:0]         col_index,
	input  wire logic signed [ELEM_W-1:0] element_value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [COL_W-1:0]              out_col,
	output logic signed [SUM_W-1:0]       dot_sum,
	output logic                          last_of_row,
	output logic                          bad_row
);

	dmm_cmd_t  cmd;
	dmm_stat_t stat;

	// sequencing
	dmm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.kind          (kind),
		.row_index     (row_index),
		.col_index     (col_index),
		.element_value (element_value),
		.stat          (stat),
		.cmd           (cmd)
	);

	// storage and arithmetic
	dmm_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_col     (out_col),
		.dot_sum     (dot_sum),
		.last_of_row (last_of_row),
		.bad_row     (bad_row)
	);

endmodule
`default_nettype wire

@@ sv/dmm_checker.sv @@
// port-level checks for the dense matrix multiply block
`default_nettype none
module dmm_checker import dmm_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic [COL_W-1:0]         out_col,
	input wire logic signed [SUM_W-1:0]  dot_sum,
	input wire logic                     last_of_row,
	input wire logic                     bad_row
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_col) && $stable(dot_sum)
			&& $stable(last_of_row) && $stable(bad_row))
		else $error("result changed while stalled");

	// a flagged row is a single zero result in column zero
	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_row |-> last_of_row && (dot_sum == '0) && (out_col == '0))
		else $error("bad row result malformed");

	// no new input while a row is still being emitted
	a_row_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_row |-> !in_ready)
		else $error("input taken in the middle of a row");

endmodule

bind dense_matrix_multiply dmm_checker u_dmm_checker (.*);
`default_nettype wire

@@ tb/tb_dense_matrix_multiply.sv @@
// self-checking testbench for the dense matrix multiply block
`timescale 1ns / 1ps
module tb_dense_matrix_multiply;
	import dmm_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam longint DOT_MAX = 64'sh1F_FFFF_FFFF;
	localparam longint DOT_MIN = -DOT_MAX - 1;
	localparam int SETTLE_CYCLES = 160;
	localparam int CYCLE_LIMIT = 1000000;

	// one expected row result
	typedef struct {
		bit [COL_W-1:0]          col;
		logic signed [SUM_W-1:0] sum;
		bit                      last;
		bit                      bad;
	} dot_result_t;

	// receiver stall patterns
	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_t;

	// row product predictor plus the queue of dot products still owed
	class row_product_board;
		logic [ELEM_W-1:0] x_mem [MAX_ROWS][MAX_INNER];
		logic [ELEM_W-1:0] y_mem [MAX_INNER][MAX_COLS];
		bit                x_set [MAX_ROWS][MAX_INNER];
		bit                y_set [MAX_INNER][MAX_COLS];
		int unsigned       rows_reg, inner_reg, cols_reg;
		bit                ytr_reg;
		dot_result_t       pending_dots [$];
		int                errors;

		function new();
			rows_reg = 1;
			inner_reg = 1;
			cols_reg = 1;
			ytr_reg = 0;
			errors = 0;
		endfunction

		function int eff_rows();
			return rows_reg < MAX_ROWS ? rows_reg : MAX_ROWS;
		endfunction

		function int eff_inner();
			return inner_reg < MAX_INNER ? inner_reg : MAX_INNER;
		endfunction

		function int eff_cols();
			return cols_reg < MAX_COLS ? cols_reg : MAX_COLS;
		endfunction

		function void set_reg(logic [1:0] idx, int unsigned value);
			case (idx)
				CFG_ROWS_N:  rows_reg = value & 7'h7F;
				CFG_INNER_D: inner_reg = value & 7'h7F;
				CFG_COLS_M:  cols_reg = value & 7'h7F;
				CFG_Y_TRANS: ytr_reg = value[0];
				default: ;
			endcase
		endfunction

		// accepted transaction: update stores or queue the row's dot products
		function void note_item(logic [1:0] k_code, logic [5:0] row, logic [5:0] col,
				logic [ELEM_W-1:0] value);
			int en, ed, em;
			longint acc;
			dot_result_t res;
			en = eff_rows();
			ed = eff_inner();
			em = eff_cols();
			case (k_code)
				KIND_LOAD_X: begin
					if (row < en && col < ed) begin
						x_mem[row][col] = value;
						x_set[row][col] = 1'b1;
					end
				end
				KIND_LOAD_Y: begin
					// transposed layout: row is the result column, col the inner index
					if (ytr_reg) begin
						if (row < em && col < ed) begin
							y_mem[col][row] = value;
							y_set[col][row] = 1'b1;
						end
					end else if (row < ed && col < em) begin
						y_mem[row][col] = value;
						y_set[row][col] = 1'b1;
					end
				end
				KIND_COMPUTE: begin
					if (row >= en) begin
						res.col = '0;
						res.sum = '0;
						res.last = 1'b1;
						res.bad = 1'b1;
						pending_dots.push_back(res);
					end else begin
						for (int j = 0; j < em; j++) begin
							acc = 0;
							for (int k = 0; k < ed; k++)
								acc += longint'($signed(x_mem[row][k])) *
									longint'($signed(y_mem[k][j]));
							if (acc > DOT_MAX)
								acc = DOT_MAX;
							if (acc < DOT_MIN)
								acc = DOT_MIN;
							res.col = COL_W'(j);
							res.sum = acc[SUM_W-1:0];
							res.last = (j == em - 1);
							res.bad = 1'b0;
							pending_dots.push_back(res);
						end
					end
				end
				default: ;
			endcase
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] mismatch: %s", $time, what);
		endtask

		// accepted result against the oldest owed dot product
		task check_dot(logic [COL_W-1:0] col, logic signed [SUM_W-1:0] sum, logic last,
				logic bad);
			dot_result_t want;
			if (pending_dots.size() == 0) begin
				report($sformatf("unexpected result col %0d sum %0d", col, sum));
				return;
			end
			want = pending_dots.pop_front();
			if (col !== want.col)
				report($sformatf("out_col %0d, want %0d", col, want.col));
			if (sum !== want.sum)
				report($sformatf("dot_sum %0d, want %0d (col %0d)", sum, want.sum, want.col));
			if (last !== want.last)
				report($sformatf("last_of_row %b, want %b (col %0d)", last, want.last, want.col));
			if (bad !== want.bad)
				report($sformatf("bad_row %b, want %b (col %0d)", bad, want.bad, want.col));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [1:0]               cfg_index;
	logic [DIM_W-1:0]         cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               kind;
	logic [ROW_W-1:0]         row_index;
	logic [COL_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;
	logic                     out_valid;
	logic                     out_ready;
	logic [COL_W-1:0]         out_col;
	logic signed [SUM_W-1:0]  dot_sum;
	logic                     last_of_row;
	logic                     bad_row;

	row_product_board sb = new();
	int burst_left = 1;
	int cycles = 0;

	dense_matrix_multiply dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.row_index(row_index),
		.col_index(col_index),
		.element_value(element_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_col(out_col),
		.dot_sum(dot_sum),
		.last_of_row(last_of_row),
		.bad_row(bad_row)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sender pacing: bursts of random length, then a short gap
	task automatic pace();
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	// one input transaction, held until accepted
	task automatic send_item(input logic [1:0] k_code, input int row, input int col,
			input int value);
		in_valid <= 1'b1;
		kind <= k_code;
		row_index <= ROW_W'(row);
		col_index <= COL_W'(col);
		element_value <= ELEM_W'(value);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_item(k_code, ROW_W'(row), COL_W'(col), ELEM_W'(value));
		pace();
	endtask

	// load logical Y(k,j) in whatever layout is configured now
	task automatic load_y(input int k, input int j, input logic [ELEM_W-1:0] value);
		if (sb.ytr_reg)
			send_item(KIND_LOAD_Y, j, k, value);
		else
			send_item(KIND_LOAD_Y, k, j, value);
	endtask

	// stop sending and wait for every owed result plus the block's tail
	task automatic drain_results(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_dots.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// write all four registers on consecutive edges
	task automatic configure(input int rows, input int inner, input int cols, input bit ytr);
		logic [1:0] idx [4];
		int vals [4];
		idx = '{CFG_ROWS_N, CFG_INNER_D, CFG_COLS_M, CFG_Y_TRANS};
		vals = '{rows, inner, cols, ytr};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= DIM_W'(vals[i]);
			@(posedge clk);
			sb.set_reg(idx[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return ELEM_W'($urandom_range(0, 65535));
		endcase
	endfunction

	// random traffic, mostly complete load-then-compute sequences
	task automatic run_random(input int budget);
		int sent, pick, en, ed, em, r;
		en = sb.eff_rows();
		ed = sb.eff_inner();
		em = sb.eff_cols();
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// fill whatever the row still lacks, then compute it
				r = $urandom_range(0, en - 1);
				for (int k = 0; k < ed; k++)
					if (!sb.x_set[r][k]) begin
						send_item(KIND_LOAD_X, r, k, rand_elem());
						sent++;
					end
				for (int k = 0; k < ed; k++)
					for (int j = 0; j < em; j++)
						if (!sb.y_set[k][j]) begin
							load_y(k, j, rand_elem());
							sent++;
						end
				send_item(KIND_COMPUTE, r, $urandom_range(0, 63), $urandom_range(0, 65535));
				sent++;
			end else if (pick < 70) begin
				// overwrite an in-range element
				if ($urandom_range(0, 1))
					send_item(KIND_LOAD_X, $urandom_range(0, en - 1), $urandom_range(0, ed - 1),
						rand_elem());
				else
					load_y($urandom_range(0, ed - 1), $urandom_range(0, em - 1), rand_elem());
				sent++;
			end else if (pick < 82) begin
				// arbitrary indices, mostly out of range
				send_item($urandom_range(0, 1) ? KIND_LOAD_Y : KIND_LOAD_X,
					$urandom_range(0, 63), $urandom_range(0, 63), rand_elem());
				sent++;
			end else if (pick < 92) begin
				if (en < MAX_ROWS) begin
					send_item(KIND_COMPUTE, $urandom_range(en, 63), $urandom_range(0, 63),
						$urandom_range(0, 65535));
					sent++;
				end
			end else if (pick < 97) begin
				send_item(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 65535));
				sent++;
			end else begin
				drain_results(0);
			end
		end
	endtask

	// receiver: check accepted results, stall on a changing pattern
	initial begin
		rx_mode_t mode;
		int seg_left;
		logic rdy;
		mode = RX_OPEN;
		seg_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_dot(out_col, dot_sum, last_of_row, bad_row);
			if (seg_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 3));
				seg_left = $urandom_range(20, 200);
			end
			seg_left--;
			case (mode)
				RX_OPEN:     rdy = 1'b1;
				RX_RANDOM:   rdy = ($urandom_range(0, 3) != 0);
				RX_PERIODIC: rdy = (seg_left % 3 == 0);
				default:     rdy = ($urandom_range(0, 7) == 0);
			endcase
			out_ready <= rdy;
		end
	end

	// stimulus
	initial begin
		int rows, inner, cols;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROWS_N;
		cfg_data <= '0;
		in_valid <= 1'b0;
		kind <= KIND_LOAD_X;
		row_index <= '0;
		col_index <= '0;
		element_value <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 2x2 times 2x3 with extreme values and the odd cases
		configure(2, 2, 3, 1'b0);
		send_item(KIND_UNUSED, 63, 63, 16'hFFFF);
		send_item(KIND_LOAD_X, 0, 0, 16'h8000);
		send_item(KIND_LOAD_X, 0, 1, 16'h7FFF);
		send_item(KIND_LOAD_X, 1, 0, 16'hFFFF);
		send_item(KIND_LOAD_X, 1, 1, 16'h0100);
		send_item(KIND_LOAD_X, 2, 0, 16'h1234);
		send_item(KIND_LOAD_X, 0, 2, 16'h4321);
		send_item(KIND_LOAD_X, 63, 63, 16'hFFFF);
		load_y(0, 0, 16'h8000);
		load_y(1, 0, 16'h8001);
		load_y(0, 1, 16'h7FFF);
		load_y(1, 1, 16'h7FFF);
		load_y(0, 2, 16'h0100);
		load_y(1, 2, 16'hFFFF);
		send_item(KIND_LOAD_Y, 2, 0, 16'h5555);
		send_item(KIND_LOAD_Y, 0, 3, 16'hAAAA);
		send_item(KIND_LOAD_Y, 63, 63, 16'hFFFF);
		send_item(KIND_COMPUTE, 0, 63, 16'hFFFF);
		send_item(KIND_COMPUTE, 1, 0, 16'h0000);
		send_item(KIND_COMPUTE, 2, 0, 16'h0000);
		send_item(KIND_COMPUTE, 63, 63, 16'hFFFF);
		drain_results(SETTLE_CYCLES);

		// extreme sizes
		configure(1, 1, 64, 1'b0);
		run_random(10);
		drain_results(SETTLE_CYCLES);
		configure(64, 3, 1, 1'b1);
		run_random(10);
		drain_results(SETTLE_CYCLES);

		// random shapes, small
		repeat (2) begin
			rows = $urandom_range(1, 64);
			inner = $urandom_range(1, 4);
			cols = $urandom_range(1, 4);
			configure(rows, inner, cols, $urandom_range(0, 1));
			run_random(8);
			drain_results(SETTLE_CYCLES);
		end

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
